/* sv/abqm_pkg.sv */
`timescale 1ns / 1ps

package abqm_pkg;

  localparam int COEF_WIDTH_DEF     = 24;
  localparam int COEF_FRAC_BITS_DEF = 20;

  localparam int SAMPLE_W  = 16;
  localparam int HIST_Y_W  = 32;
  localparam int REG_IDX_W = 3;
  localparam int NUM_TAPS  = 5;

  typedef enum logic [1:0] {
    MODE_BYPASS = 2'd0,
    MODE_FILTER = 2'd1,
    MODE_MASK   = 2'd2
  } mode_t;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B0  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B1  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B2  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_FB1 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_FB2 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_AND_MASK = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_XOR_MASK = 3'd7;

  // tap order in the coefficient array
  localparam int TAP_B0  = 0;
  localparam int TAP_B1  = 1;
  localparam int TAP_B2  = 2;
  localparam int TAP_FB1 = 3;
  localparam int TAP_FB2 = 4;

  localparam logic [SAMPLE_W-1:0] AND_MASK_RST = 16'hFFFF;

  typedef struct packed {
    mode_t               mode;
    logic [SAMPLE_W-1:0] and_mask;
    logic [SAMPLE_W-1:0] xor_mask;
  } ctrl_t;

endpackage

/* sv/abqm_in_if.sv */
`timescale 1ns / 1ps

interface abqm_in_if;
  import abqm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

/* sv/abqm_out_if.sv */
`timescale 1ns / 1ps

interface abqm_out_if;
  import abqm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

/* sv/abqm_cfg_if.sv */
`timescale 1ns / 1ps

interface abqm_cfg_if #(
  parameter int DATA_W = abqm_pkg::COEF_WIDTH_DEF
);
  import abqm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/abqm_cfg_regs.sv */
`timescale 1ns / 1ps

module abqm_cfg_regs #(
  parameter int COEF_WIDTH = abqm_pkg::COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  abqm_cfg_if.sink                     cfg_if,
  output abqm_pkg::ctrl_t              ctrl,
  output logic signed [COEF_WIDTH-1:0] coef [abqm_pkg::NUM_TAPS]
);
  import abqm_pkg::*;

  ctrl_t                        ctrl_r;
  logic signed [COEF_WIDTH-1:0] coef_r [NUM_TAPS];

  assign cfg_if.ready = 1'b1;
  assign ctrl         = ctrl_r;
  assign coef         = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.mode     <= MODE_BYPASS;
      ctrl_r.and_mask <= AND_MASK_RST;
      ctrl_r.xor_mask <= '0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_MODE:     ctrl_r.mode     <= mode_t'(cfg_if.data[1:0]);
        REG_COEF_B0:  coef_r[TAP_B0]  <= cfg_if.data;
        REG_COEF_B1:  coef_r[TAP_B1]  <= cfg_if.data;
        REG_COEF_B2:  coef_r[TAP_B2]  <= cfg_if.data;
        REG_COEF_FB1: coef_r[TAP_FB1] <= cfg_if.data;
        REG_COEF_FB2: coef_r[TAP_FB2] <= cfg_if.data;
        REG_AND_MASK: ctrl_r.and_mask <= cfg_if.data[SAMPLE_W-1:0];
        REG_XOR_MASK: ctrl_r.xor_mask <= cfg_if.data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/abqm_biquad.sv */
`timescale 1ns / 1ps

module abqm_biquad #(
  parameter int COEF_WIDTH     = abqm_pkg::COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = abqm_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_en,
  input  logic        [abqm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [COEF_WIDTH-1:0]        coef [abqm_pkg::NUM_TAPS],
  output logic        [abqm_pkg::SAMPLE_W-1:0] result
);
  import abqm_pkg::*;

  localparam int PROD_W = COEF_WIDTH + HIST_Y_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W:0] HALF  = {{SUM_W{1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W:0] Y_MAX = (SUM_W + 1)'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W:0] Y_MIN = (SUM_W + 1)'(32'sh8000_0000);

  localparam logic signed [HIST_Y_W:0] OUT_BIAS = (HIST_Y_W + 1)'(33'sd32768);
  localparam logic signed [HIST_Y_W:0] OUT_MAX  = (HIST_Y_W + 1)'(33'sd65535);

  logic signed [SAMPLE_W-1:0] x_hist1_r, x_hist2_r;
  logic signed [HIST_Y_W-1:0] y_hist1_r, y_hist2_r;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [PROD_W-1:0]   prod [NUM_TAPS];
  logic signed [SUM_W-1:0]    acc;
  logic signed [SUM_W:0]      rounded;
  logic signed [HIST_Y_W-1:0] y;
  logic signed [HIST_Y_W:0]   biased;

  // centre: offset binary to two's complement
  assign x = {~sample[SAMPLE_W-1], sample[SAMPLE_W-2:0]};

  always_comb begin
    prod[TAP_B0]  = coef[TAP_B0] * x;
    prod[TAP_B1]  = coef[TAP_B1] * x_hist1_r;
    prod[TAP_B2]  = coef[TAP_B2] * x_hist2_r;
    prod[TAP_FB1] = coef[TAP_FB1] * y_hist1_r;
    prod[TAP_FB2] = coef[TAP_FB2] * y_hist2_r;
  end

  generate
    if (PROD_W <= 60) begin : g_plain_sum
      // partial sums never reach the 2^61 clamp at these widths
      always_comb begin
        acc = SUM_W'(prod[TAP_B0]) + SUM_W'(prod[TAP_B1]) + SUM_W'(prod[TAP_B2])
            + SUM_W'(prod[TAP_FB1]) + SUM_W'(prod[TAP_FB2]);
      end
    end else begin : g_sat_sum
      localparam logic signed [SUM_W-1:0] ACC_LIM = {{(SUM_W-1){1'b0}}, 1'b1} << 61;
      always_comb begin
        logic signed [SUM_W-1:0] s;
        acc = '0;
        for (int i = 0; i < NUM_TAPS; i++) begin
          s = acc + SUM_W'(prod[i]);
          if (s > ACC_LIM) begin
            acc = ACC_LIM;
          end else if (s < -ACC_LIM) begin
            acc = -ACC_LIM;
          end else begin
            acc = s;
          end
        end
      end
    end
  endgenerate

  // round half up, then clamp to the 32-bit history range
  assign rounded = ((SUM_W + 1)'(acc) + HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    if (rounded > Y_MAX) begin
      y = HIST_Y_W'(Y_MAX);
    end else if (rounded < Y_MIN) begin
      y = HIST_Y_W'(Y_MIN);
    end else begin
      y = rounded[HIST_Y_W-1:0];
    end
  end

  assign biased = (HIST_Y_W + 1)'(y) + OUT_BIAS;

  always_comb begin
    if (biased < 0) begin
      result = '0;
    end else if (biased > OUT_MAX) begin
      result = '1;
    end else begin
      result = biased[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_hist1_r <= '0;
      x_hist2_r <= '0;
      y_hist1_r <= '0;
      y_hist2_r <= '0;
    end else if (step_en) begin
      x_hist1_r <= x;
      x_hist2_r <= x_hist1_r;
      y_hist1_r <= y;
      y_hist2_r <= y_hist1_r;
    end
  end

endmodule

/* sv/audio_biquad_or_mask_effect_unit.sv */
`timescale 1ns / 1ps

// Effect stage for 16-bit offset-binary audio: bypass, a direct-form-I biquad with
// signed Q-format coefficients (rounded half up, output saturated to 0..65535), or
// an and-then-xor mask, chosen by the mode register. One sample is accepted every
// cycle while the output is not stalled; its result passes through the input
// register, then the result register; the filter's feedback path is combinational
// through the five coefficient multipliers, the sum and the rounding into the
// history registers. Filter history changes only on samples handled in filter
// mode and is cleared by reset. The user must write registers over the cfg port
// only while no sample is in flight; the block itself does not enforce this.
module audio_biquad_or_mask_effect_unit #(
  parameter int COEF_WIDTH     = abqm_pkg::COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = abqm_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  abqm_in_if.sink     in_if,
  abqm_out_if.source  out_if,
  abqm_cfg_if.sink    cfg_if
);
  import abqm_pkg::*;

  ctrl_t                        ctrl;
  logic signed [COEF_WIDTH-1:0] coef [NUM_TAPS];

  logic                s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                advance;
  logic                in_beat;
  logic [SAMPLE_W-1:0] filt_result;

  abqm_cfg_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .ctrl   (ctrl),
    .coef   (coef)
  );

  abqm_biquad #(
    .COEF_WIDTH     (COEF_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_biquad (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance && (ctrl.mode == MODE_FILTER)),
    .sample  (s1_sample_r),
    .coef    (coef),
    .result  (filt_result)
  );

  // sample moves on when the result register is free or being drained
  assign advance      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || advance;
  assign in_beat      = in_if.valid && in_if.ready;

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;

  always_comb begin
    unique case (ctrl.mode)
      MODE_FILTER: out_sample_nxt = filt_result;
      MODE_MASK:   out_sample_nxt = (s1_sample_r & ctrl.and_mask) ^ ctrl.xor_mask;
      MODE_BYPASS: out_sample_nxt = s1_sample_r;
      default:     out_sample_nxt = s1_sample_r;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_sample_r <= in_if.sample_in;
    end
    if (advance) begin
      out_sample_r <= out_sample_nxt;
    end
  end

endmodule

/* bench/audio_biquad_or_mask_effect_unit_test.sv */
`timescale 1ns / 1ps

module audio_biquad_or_mask_effect_unit_test;
  import abqm_pkg::*;

  localparam int CW          = COEF_WIDTH_DEF;
  localparam int FRAC        = COEF_FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 70;

  localparam longint ACC_LIM = 64'sh2000_0000_0000_0000;
  localparam longint Y_MAX   = 64'sd2147483647;
  localparam longint Y_MIN   = -64'sd2147483648;

  // mode 3 has no enum member and behaves as bypass
  localparam logic [1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CW-1:0] COEF_ONE    = CW'(1 << FRAC);
  localparam logic [CW-1:0] COEF_HALF   = CW'(1 << (FRAC - 1));
  localparam logic [CW-1:0] COEF_MAX    = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_MIN    = {1'b1, {(CW-1){1'b0}}};

  class effect_scoreboard;
    logic [1:0]           mode;
    logic signed [CW-1:0] coef [NUM_TAPS];
    logic [SAMPLE_W-1:0]  and_mask;
    logic [SAMPLE_W-1:0]  xor_mask;
    int                   x_hist [2];
    int                   y_hist [2];
    logic [SAMPLE_W-1:0]  expected_samples [$];
    int                   errors;

    function new();
      mode = MODE_BYPASS;
      foreach (coef[i]) coef[i] = '0;
      and_mask = AND_MASK_RST;
      xor_mask = '0;
      x_hist[0] = 0;
      x_hist[1] = 0;
      y_hist[0] = 0;
      y_hist[1] = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] data);
      case (idx)
        REG_MODE:     mode = data[1:0];
        REG_COEF_B0:  coef[TAP_B0] = data;
        REG_COEF_B1:  coef[TAP_B1] = data;
        REG_COEF_B2:  coef[TAP_B2] = data;
        REG_COEF_FB1: coef[TAP_FB1] = data;
        REG_COEF_FB2: coef[TAP_FB2] = data;
        REG_AND_MASK: and_mask = data[SAMPLE_W-1:0];
        REG_XOR_MASK: xor_mask = data[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sat_add(longint acc, longint term);
      longint s;
      s = acc + term;
      if (s > ACC_LIM) return ACC_LIM;
      if (s < -ACC_LIM) return -ACC_LIM;
      return s;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      int                  x;
      longint              acc;
      longint              y;
      longint              o;
      logic [SAMPLE_W-1:0] r;
      r = s;
      if (mode == MODE_FILTER) begin
        x = int'(s) - 32768;
        acc = sat_add(0, longint'(coef[TAP_B0]) * x);
        acc = sat_add(acc, longint'(coef[TAP_B1]) * x_hist[0]);
        acc = sat_add(acc, longint'(coef[TAP_B2]) * x_hist[1]);
        acc = sat_add(acc, longint'(coef[TAP_FB1]) * y_hist[0]);
        acc = sat_add(acc, longint'(coef[TAP_FB2]) * y_hist[1]);
        // round half up, arithmetic shift gives the floor
        y = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (y > Y_MAX) y = Y_MAX;
        if (y < Y_MIN) y = Y_MIN;
        o = y + 32768;
        if (o < 0) o = 0;
        if (o > 65535) o = 65535;
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = int'(y);
        r = o[SAMPLE_W-1:0];
      end else if (mode == MODE_MASK) begin
        r = (s & and_mask) ^ xor_mask;
      end
      expected_samples.push_back(r);
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat: sample_out %h", got);
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("sample_out mismatch: expected %h, got %h", want, got);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  bit   hold_out;
  int   idle_cycles;

  effect_scoreboard sb = new();

  abqm_in_if                  in_ch ();
  abqm_out_if                 out_ch ();
  abqm_cfg_if #(.DATA_W(CW))  cfg_ch ();

  audio_biquad_or_mask_effect_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_out && ($urandom_range(99) >= out_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_sample(out_ch.sample_out);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  // leaves valid high so back-to-back writes need no extra edge
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic close_cfg();
    cfg_ch.valid <= 1'b0;
  endtask

  // upper data bits are noise, only the low two select the mode
  task automatic set_mode(logic [1:0] m);
    logic [CW-1:0] d;
    d = CW'($urandom());
    d[1:0] = m;
    write_reg(REG_MODE, d);
  endtask

  task automatic program_all(logic [1:0] m, logic [CW-1:0] b0, logic [CW-1:0] b1,
                             logic [CW-1:0] b2, logic [CW-1:0] fb1, logic [CW-1:0] fb2,
                             logic [SAMPLE_W-1:0] am, logic [SAMPLE_W-1:0] xm);
    logic [CW-1:0] d;
    set_mode(m);
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_COEF_FB1, fb1);
    write_reg(REG_COEF_FB2, fb2);
    d = CW'($urandom());
    d[SAMPLE_W-1:0] = am;
    write_reg(REG_AND_MASK, d);
    d = CW'($urandom());
    d[SAMPLE_W-1:0] = xm;
    write_reg(REG_XOR_MASK, d);
    close_cfg();
  endtask

  // block is idle once every sample has come back and the pipe has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic hold_output();
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
  endtask

  function automatic logic [CW-1:0] rand_coef(int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    return v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] rand_word();
    return CW'($urandom());
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_mask();
    return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [1:0] m;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    hold_out        = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // bypass straight out of reset
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain();

    // mask mode with reset masks, then real masks
    set_mode(MODE_MASK);
    close_cfg();
    send_sample(16'h1234);
    drain();
    write_reg(REG_AND_MASK, 24'h00F0F0);
    write_reg(REG_XOR_MASK, 24'h0000FF);
    close_cfg();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    drain();

    set_mode(MODE_UNUSED);
    close_cfg();
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    drain();

    // unity gain filter
    program_all(MODE_FILTER, COEF_ONE, '0, '0, '0, '0, 16'hFFFF, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    drain();

    // half gain: +0.5 rounds up, -0.5 rounds to zero
    write_reg(REG_COEF_B0, COEF_HALF);
    close_cfg();
    send_sample(16'h8001);
    send_sample(16'h7FFF);
    drain();

    // extreme coefficients drive saturation both ways
    program_all(MODE_FILTER, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                16'hFFFF, 16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    drain();

    // history must hold across a non-filter sample
    set_mode(MODE_BYPASS);
    close_cfg();
    send_sample(16'h1234);
    drain();
    set_mode(MODE_FILTER);
    close_cfg();
    send_sample(16'h8000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 74; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 74; end
        default: begin in_idle_pct = 17; out_stall_pct = 17; end
      endcase
      if (p == 0) begin
        program_all(MODE_FILTER, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                    rand_mask(), rand_mask());
      end else if (p == 1) begin
        program_all(MODE_FILTER, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                    rand_mask(), rand_mask());
      end else if (p % 5 == 2) begin
        case ($urandom_range(2))
          0:       m = MODE_BYPASS;
          1:       m = MODE_UNUSED;
          default: m = MODE_MASK;
        endcase
        if (p == 2) m = MODE_MASK;
        program_all(m, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_mask(), rand_mask());
      end else if (p % 2 == 1) begin
        // mostly well-behaved filter around unity scale
        program_all(MODE_FILTER, rand_coef(1 << 19), rand_coef(1 << 19), rand_coef(1 << 19),
                    rand_coef(1 << 21), rand_coef(1 << 20), rand_mask(), rand_mask());
      end else begin
        program_all(MODE_FILTER, rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_mask(), rand_mask());
      end
      // receiver goes quiet while samples keep coming, so the input backs up
      if (p == 4) begin
        fork
          hold_output();
        join_none
      end
      repeat (PHASE_ITEMS) send_sample(rand_sample());
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
